// ===== rtl/lcgrc_pkg.sv =====
package lcgrc_pkg;

    // field widths
    localparam int unsigned WordW    = 32;
    localparam int unsigned ValueW   = 64;
    localparam int unsigned ActionW  = 2;
    localparam int unsigned SelW     = 2;
    localparam int unsigned CountW   = 7;
    localparam int unsigned CharW    = 8;
    localparam int unsigned SizeW    = 6;

    // generator constants
    localparam logic [WordW-1:0] LcgMul    = 32'd1664525;
    localparam logic [WordW-1:0] LcgAdd    = 32'd1013904223;
    localparam logic [WordW-1:0] ResetSeed = 32'd987654321;

    // action codes
    typedef enum logic [ActionW-1:0] {
        ACT_RAW   = 2'd0,
        ACT_RANGE = 2'd1,
        ACT_CHARS = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    // charset codes, the unused code falls back to hex
    typedef enum logic [SelW-1:0] {
        CS_MIXED = 2'd0,
        CS_UPPER = 2'd1,
        CS_HEX   = 2'd2,
        CS_SPARE = 2'd3
    } t_charset;

    // one generator advance, a full-ones sum wraps to zero
    function automatic logic [WordW-1:0] lcg_next(input logic [WordW-1:0] w);
        logic [WordW-1:0] t;
        t = WordW'(w * LcgMul + LcgAdd);
        if (t == '1) begin
            t = '0;
        end
        return t;
    endfunction

    // number of symbols in a charset
    function automatic logic [SizeW-1:0] charset_size(input t_charset sel);
        logic [SizeW-1:0] s;
        case (sel)
            CS_MIXED: s = 6'd62;
            CS_UPPER: s = 6'd36;
            default:  s = 6'd16;
        endcase
        return s;
    endfunction

    // ascii code of symbol key within a charset
    function automatic logic [CharW-1:0] charset_char(input t_charset sel,
                                                      input logic [SizeW-1:0] key);
        logic [CharW-1:0] k;
        logic [CharW-1:0] c;
        k = CharW'(key);
        case (sel)
            CS_MIXED: begin
                if (k < 8'd26) begin
                    c = 8'h61 + k;
                end else if (k < 8'd52) begin
                    c = 8'h41 + (k - 8'd26);
                end else begin
                    c = 8'h30 + (k - 8'd52);
                end
            end
            CS_UPPER: begin
                if (k < 8'd26) begin
                    c = 8'h41 + k;
                end else begin
                    c = 8'h30 + (k - 8'd26);
                end
            end
            default: begin
                if (k < 8'd6) begin
                    c = 8'h41 + k;
                end else begin
                    c = 8'h30 + (k - 8'd6);
                end
            end
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/lcgrc_if.sv =====
interface lcgrc_in_if
    import lcgrc_pkg::*;
    ;
    logic               valid;
    logic               ready;
    logic [ActionW-1:0] action;
    logic [ValueW-1:0]  range_begin;
    logic [ValueW-1:0]  range_end;
    logic [SelW-1:0]    charset_select;
    logic [CountW-1:0]  char_count;

    modport source (
        output valid, action, range_begin, range_end, charset_select, char_count,
        input  ready
    );
    modport sink (
        input  valid, action, range_begin, range_end, charset_select, char_count,
        output ready
    );
endinterface

interface lcgrc_out_if
    import lcgrc_pkg::*;
    ;
    logic              valid;
    logic              ready;
    logic [ValueW-1:0] value;
    logic              last;
    logic              end_zero_flag;

    modport source (
        output valid, value, last, end_zero_flag,
        input  ready
    );
    modport sink (
        input  valid, value, last, end_zero_flag,
        output ready
    );
endinterface

// ===== rtl/lcg_range_and_charset_generator.sv =====
// Linear congruential random source (multiplier 1664525, increment 1013904223, a
// full-ones word folds to zero) with three actions: a raw 32-bit word, a range draw
// that reduces two words as a 64-bit value modulo range_end and adds range_begin when
// the remainder is below it, and a run of ASCII characters. Items are taken one at a
// time; the input is ready only when the previous item is fully worked off, and the
// last result may still wait in the output register while the next item is taken.
// A range draw goes through the restoring remainder unit, which shifts in one
// dividend bit per cycle; a zero range_end skips it. A character run handles each
// character as one generator advance, the symbol index reduced 8 bits per cycle,
// and the load of the output. Each output load waits while the output register is
// still full. Writing the seed register reloads the generator word; the register
// is written only while the block is idle.
module lcg_range_and_charset_generator
    import lcgrc_pkg::*;
#(
    parameter int unsigned MAX_CHARS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    lcgrc_in_if.sink          i_in,
    lcgrc_out_if.source       o_out,
    input  logic              i_cfg_wr_en,
    input  logic [WordW-1:0]  i_cfg_wr_data
);

    // run length limit, clipped to what the count field can hold
    localparam int unsigned CountMax  = (1 << CountW) - 1;
    localparam int unsigned SatLimit  = (MAX_CHARS > CountMax) ? CountMax : MAX_CHARS;
    localparam logic [CountW-1:0] CharLimit = CountW'(SatLimit);

    // remainder unit sizing
    localparam int unsigned DivCntW     = $clog2(ValueW);
    localparam int unsigned ModBits     = 8;
    localparam int unsigned ModCycles   = WordW / ModBits;
    localparam int unsigned ModCntW     = $clog2(ModCycles);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RAW_OUT,
        ST_RANGE_ADV,
        ST_DIV,
        ST_RANGE_OUT,
        ST_CHAR_ADV,
        ST_CHAR_MOD,
        ST_CHAR_OUT
    } t_state;

    t_state              r_state;
    logic [WordW-1:0]    r_word;
    logic [CountW-1:0]   r_chars_left;
    t_charset            r_charset;
    logic [ValueW-1:0]   r_begin;
    logic [ValueW-1:0]   r_end;
    logic                r_zero;
    logic [ValueW-1:0]   r_num;
    logic [ValueW-1:0]   r_rem;
    logic [DivCntW-1:0]  r_div_cnt;
    logic [ModCntW-1:0]  r_mod_cnt;
    logic [WordW-1:0]    r_shift;
    logic [SizeW-1:0]    r_mod;
    logic                r_out_valid;
    logic [ValueW-1:0]   r_out_value;
    logic                r_out_last;
    logic                r_out_flag;

    logic [WordW-1:0]    word_next;
    logic                out_free;
    logic                out_load;
    logic [ValueW:0]     div_trial;
    logic [ValueW-1:0]   div_rem;
    logic [SizeW-1:0]    mod_next;
    logic [SizeW-1:0]    cs_size;
    logic [CountW-1:0]   count_sat;
    logic [ValueW-1:0]   range_value;

    assign word_next = lcg_next(r_word);
    assign out_free  = !r_out_valid || o_out.ready;
    assign out_load  = out_free && (r_state inside {ST_RAW_OUT, ST_RANGE_OUT, ST_CHAR_OUT});

    // one restoring remainder step, one dividend bit per cycle
    always_comb begin
        div_trial = {r_rem, r_num[ValueW-1]};
        if (div_trial >= {1'b0, r_end}) begin
            div_rem = ValueW'(div_trial - {1'b0, r_end});
        end else begin
            div_rem = div_trial[ValueW-1:0];
        end
    end

    // symbol index reduction, eight word bits per cycle
    always_comb begin
        logic [SizeW:0] t;
        cs_size  = charset_size(r_charset);
        mod_next = r_mod;
        for (int b = 0; b < ModBits; b++) begin
            t = {mod_next, r_shift[WordW-1-b]};
            if (t >= {1'b0, cs_size}) begin
                t = t - {1'b0, cs_size};
            end
            mod_next = t[SizeW-1:0];
        end
    end

    // range result, begin added when the remainder falls below it
    assign range_value = r_zero ? '0 :
                         (r_rem < r_begin) ? (r_rem + r_begin) : r_rem;

    assign count_sat = (i_in.char_count > CharLimit) ? CharLimit : i_in.char_count;

    // sequencer, generator state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_word       <= ResetSeed;
            r_chars_left <= '0;
            r_charset    <= CS_MIXED;
            r_out_valid  <= 1'b0;
        end else begin
            // a new load fills the slot, an output transfer frees it
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (i_cfg_wr_en) begin
                        r_word <= i_cfg_wr_data;
                    end
                    if (i_in.valid) begin
                        case (t_action'(i_in.action))
                            ACT_RAW: begin
                                r_word  <= word_next;
                                r_state <= ST_RAW_OUT;
                            end
                            ACT_RANGE: begin
                                r_word  <= word_next;
                                r_begin <= i_in.range_begin;
                                r_end   <= i_in.range_end;
                                r_state <= ST_RANGE_ADV;
                            end
                            ACT_CHARS: begin
                                r_charset    <= t_charset'(i_in.charset_select);
                                r_chars_left <= count_sat;
                                if (count_sat != '0) begin
                                    r_state <= ST_CHAR_ADV;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end

                ST_RAW_OUT: begin
                    if (out_free) begin
                        r_out_value <= ValueW'(r_word);
                        r_out_last  <= 1'b1;
                        r_out_flag  <= 1'b0;
                        r_state     <= ST_IDLE;
                    end
                end

                // second draw forms the low half of the dividend
                ST_RANGE_ADV: begin
                    r_word    <= word_next;
                    r_num     <= {r_word, word_next};
                    r_rem     <= '0;
                    r_div_cnt <= '0;
                    r_zero    <= (r_end == '0);
                    r_state   <= (r_end == '0) ? ST_RANGE_OUT : ST_DIV;
                end

                ST_DIV: begin
                    r_rem     <= div_rem;
                    r_num     <= {r_num[ValueW-2:0], 1'b0};
                    r_div_cnt <= r_div_cnt + 1'b1;
                    if (r_div_cnt == '1) begin
                        r_state <= ST_RANGE_OUT;
                    end
                end

                ST_RANGE_OUT: begin
                    if (out_free) begin
                        r_out_value <= range_value;
                        r_out_last  <= 1'b1;
                        r_out_flag  <= r_zero;
                        r_state     <= ST_IDLE;
                    end
                end

                ST_CHAR_ADV: begin
                    r_word    <= word_next;
                    r_shift   <= word_next;
                    r_mod     <= '0;
                    r_mod_cnt <= '0;
                    r_state   <= ST_CHAR_MOD;
                end

                ST_CHAR_MOD: begin
                    r_mod     <= mod_next;
                    r_shift   <= {r_shift[WordW-ModBits-1:0], ModBits'(0)};
                    r_mod_cnt <= r_mod_cnt + 1'b1;
                    if (r_mod_cnt == '1) begin
                        r_state <= ST_CHAR_OUT;
                    end
                end

                ST_CHAR_OUT: begin
                    if (out_free) begin
                        r_out_value  <= ValueW'(charset_char(r_charset, r_mod));
                        r_out_last   <= (r_chars_left == CountW'(1));
                        r_out_flag   <= 1'b0;
                        r_chars_left <= r_chars_left - 1'b1;
                        r_state      <= (r_chars_left == CountW'(1)) ? ST_IDLE : ST_CHAR_ADV;
                    end
                end

                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // port drive
    assign i_in.ready          = (r_state == ST_IDLE);
    assign o_out.valid         = r_out_valid;
    assign o_out.value         = r_out_value;
    assign o_out.last          = r_out_last;
    assign o_out.end_zero_flag = r_out_flag;

endmodule
